### hw/rtl/sip21_pkg.sv
// Shared types, constants and the SipRound function for the SipHash-2-1
// single-word hasher. No dependencies.
package sip21_pkg;

   localparam int unsigned WORD_W = 64;
   localparam int unsigned CSR_INDEX_W = 8;

   localparam int unsigned DEF_COMPRESSION_ROUNDS = 2;
   localparam int unsigned DEF_FINAL_ROUNDS = 1;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LOW = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_HIGH = 8'd1;

   // Initialization constants and finalization mark
   localparam logic [WORD_W-1:0] IV0 = 64'h736f6d6570736575;
   localparam logic [WORD_W-1:0] IV1 = 64'h646f72616e646f6d;
   localparam logic [WORD_W-1:0] IV2 = 64'h6c7967656e657261;
   localparam logic [WORD_W-1:0] IV3 = 64'h7465646279746573;
   localparam logic [WORD_W-1:0] FINAL_MARK = 64'h00000000000000ff;

   // Four 64-bit state words, v0 in element 0
   typedef logic [3:0][WORD_W-1:0] sip21_state_type;

   // One SipRound: add-rotate-xor network, two dependent adds deep
   function automatic sip21_state_type sip_round(input sip21_state_type s);
      logic [WORD_W-1:0] v0;
      logic [WORD_W-1:0] v1;
      logic [WORD_W-1:0] v2;
      logic [WORD_W-1:0] v3;
      sip21_state_type   r;
      v0 = s[0] + s[1];
      v2 = s[2] + s[3];
      v1 = {s[1][50:0], s[1][63:51]} ^ v0;
      v3 = {s[3][47:0], s[3][63:48]} ^ v2;
      v0 = {v0[31:0], v0[63:32]};
      v2 = v2 + v1;
      v0 = v0 + v3;
      v1 = {v1[46:0], v1[63:47]} ^ v2;
      v3 = {v3[42:0], v3[63:43]} ^ v0;
      v2 = {v2[31:0], v2[63:32]};
      r[0] = v0;
      r[1] = v1;
      r[2] = v2;
      r[3] = v3;
      return r;
   endfunction

endpackage

### hw/rtl/sip21_round.sv
// One pipelined SipRound stage with its valid bit and message carry.
// Depends on sip21_pkg.
module sip21_round
   import sip21_pkg::*;
#(
   parameter bit FINAL_ENTRY = 1'b0
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic            in_valid,
   input  sip21_state_type in_state,
   input  logic [WORD_W-1:0] in_msg,
   output logic            out_valid,
   output sip21_state_type out_state,
   output logic [WORD_W-1:0] out_msg
);

   logic            valid_ff;
   sip21_state_type state_ff;
   sip21_state_type state_in;
   sip21_state_type pre_state;
   logic [WORD_W-1:0] msg_ff;

   // First finalization stage folds the message into v0 and marks v2
   always_comb begin
      pre_state = in_state;
      if (FINAL_ENTRY) begin
         pre_state[0] = in_state[0] ^ in_msg;
         pre_state[2] = in_state[2] ^ FINAL_MARK;
      end
      state_in = sip_round(pre_state);
   end

   // Stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff <= state_in;
         msg_ff   <= in_msg;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;
   assign out_msg   = msg_ff;

endmodule

### hw/rtl/siphash_2_1_single_word_top.sv
// Pipeline: an accepted word passes the input-stage register, one register per SipRound
// (compression rounds, then final rounds) and the output register that holds its tag.
// Throughput: one word per cycle; the whole pipeline holds while rsp is stalled.
// Reset: synchronous, clears all stage valid bits and both key registers to 0.
// Depends on sip21_pkg and sip21_round.
module siphash_2_1_single_word_top
   import sip21_pkg::*;
#(
   parameter int unsigned COMPRESSION_ROUNDS = DEF_COMPRESSION_ROUNDS,
   parameter int unsigned FINAL_ROUNDS = DEF_FINAL_ROUNDS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [WORD_W-1:0]      req_message_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [WORD_W-1:0]      rsp_tag,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_data
);

   localparam int unsigned NUM_ROUNDS = COMPRESSION_ROUNDS + FINAL_ROUNDS;

   logic [WORD_W-1:0] key_low_ff;
   logic [WORD_W-1:0] key_high_ff;
   logic              advance;
   logic              rsp_valid_ff;
   logic [WORD_W-1:0] tag_ff;
   logic [WORD_W-1:0] tag_in;
   sip21_state_type   init_in;

   logic              st_valid [0:NUM_ROUNDS];
   sip21_state_type   st_state [0:NUM_ROUNDS];
   logic [WORD_W-1:0] st_msg   [0:COMPRESSION_ROUNDS];

   // Key registers, always writable
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_KEY_LOW:  key_low_ff  <= csr_data;
            CSR_KEY_HIGH: key_high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Pipeline moves whenever the output register is empty or draining
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Input stage: key-loaded state with the message in v3
   always_comb begin
      init_in[0] = IV0 ^ key_low_ff;
      init_in[1] = IV1 ^ key_high_ff;
      init_in[2] = IV2 ^ key_low_ff;
      init_in[3] = IV3 ^ key_high_ff ^ req_message_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid[0] <= 1'b0;
      end else if (advance) begin
         st_valid[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_state[0] <= init_in;
         st_msg[0]   <= req_message_word;
      end
   end

   // Round stages
   for (genvar k = 1; k <= NUM_ROUNDS; k++) begin : g_round
      if (k <= COMPRESSION_ROUNDS) begin : g_comp
         sip21_round #(.FINAL_ENTRY(1'b0)) u_round (
            .clock     (clock),
            .reset     (reset),
            .advance   (advance),
            .in_valid  (st_valid[k-1]),
            .in_state  (st_state[k-1]),
            .in_msg    (st_msg[k-1]),
            .out_valid (st_valid[k]),
            .out_state (st_state[k]),
            .out_msg   (st_msg[k])
         );
      end else if (k == COMPRESSION_ROUNDS + 1) begin : g_fin_entry
         sip21_round #(.FINAL_ENTRY(1'b1)) u_round (
            .clock     (clock),
            .reset     (reset),
            .advance   (advance),
            .in_valid  (st_valid[k-1]),
            .in_state  (st_state[k-1]),
            .in_msg    (st_msg[COMPRESSION_ROUNDS]),
            .out_valid (st_valid[k]),
            .out_state (st_state[k]),
            .out_msg   ()
         );
      end else begin : g_fin
         sip21_round #(.FINAL_ENTRY(1'b0)) u_round (
            .clock     (clock),
            .reset     (reset),
            .advance   (advance),
            .in_valid  (st_valid[k-1]),
            .in_state  (st_state[k-1]),
            .in_msg    ('0),
            .out_valid (st_valid[k]),
            .out_state (st_state[k]),
            .out_msg   ()
         );
      end
   end

   // Output register: fold the four words into the tag
   assign tag_in = st_state[NUM_ROUNDS][0] ^ st_state[NUM_ROUNDS][1]
                 ^ st_state[NUM_ROUNDS][2] ^ st_state[NUM_ROUNDS][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= st_valid[NUM_ROUNDS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag_ff <= tag_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_tag   = tag_ff;

endmodule
